[rtl/bts_pkg.sv]
// Shared types and constants of the token set engine.
package bts_pkg;

    // Width of the operation field and its codes.
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_TEST   = 3'd3;
    localparam logic [OP_W-1:0] OP_MERGE  = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;
    localparam logic [OP_W-1:0] OP_DISJ   = 3'd6;

    // Field widths of the command word.
    localparam int SET_W   = 6;
    localparam int TOKEN_W = 8;

    // Result count field and its saturation value.
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Queue between front and back; the depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Classified operation as it travels from the front to the back.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            a_ok;
        logic            b_ok;
        logic            c_ok;
        logic            tok_ok;
    } cmd_t;

endpackage

[rtl/bts_front.sv]
// Front end: checks the set indexes and the token against the configured
// limits, splits the token into word index and bit position, and forms the
// base address of each named set.
module bts_front #(
    parameter int NUM_SETS    = 64,
    parameter int TOKEN_LIMIT = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic [bts_pkg::OP_W-1:0]    operation,
    input  logic [bts_pkg::SET_W-1:0]   set_a,
    input  logic [bts_pkg::SET_W-1:0]   set_b,
    input  logic [bts_pkg::SET_W-1:0]   set_c,
    input  logic [bts_pkg::TOKEN_W-1:0] token,
    output bts_pkg::cmd_t               cmd,
    output logic [$clog2(NUM_SETS * ((TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH))-1:0] base_a,
    output logic [$clog2(NUM_SETS * ((TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH))-1:0] base_b,
    output logic [$clog2(NUM_SETS * ((TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH))-1:0] base_c,
    output logic [(((TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH) > 1 ?
                   $clog2((TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH) : 1)-1:0] widx,
    output logic [$clog2(WORD_WIDTH)-1:0] bitpos
);

    localparam int WPS     = (TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int DEPTH   = NUM_SETS * WPS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIDX_W  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int BIT_W   = $clog2(WORD_WIDTH);
    localparam int TW      = bts_pkg::TOKEN_W;
    // Number of word boundaries that an 8-bit token can cross.
    localparam int MAXK    = ((1 << TW) - 1) / WORD_WIDTH;

    logic [MAXK-1:0] thermo;
    logic [TW-1:0]   word_num;
    logic [TW-1:0]   word_start;

    // Each bit says the token lies at or beyond one word boundary; their
    // count is the word index.
    always_comb
    begin
        for (int k = 0; k < MAXK; k++)
        begin
            thermo[k] = ({24'd0, token} >= (k + 1) * WORD_WIDTH);
        end
    end

    assign word_num   = TW'($countones(thermo));
    assign word_start = TW'(32'(word_num) * WORD_WIDTH);
    assign widx       = WIDX_W'(word_num);
    assign bitpos     = BIT_W'(token - word_start);

    assign cmd.op     = operation;
    assign cmd.a_ok   = ({26'd0, set_a} < NUM_SETS);
    assign cmd.b_ok   = ({26'd0, set_b} < NUM_SETS);
    assign cmd.c_ok   = ({26'd0, set_c} < NUM_SETS);
    assign cmd.tok_ok = ({24'd0, token} < TOKEN_LIMIT);

    // A set out of range never reaches the store, so its base is parked at 0.
    assign base_a = cmd.a_ok ? ADDR_W'(ADDR_W'(set_a) * ADDR_W'(WPS)) : '0;
    assign base_b = cmd.b_ok ? ADDR_W'(ADDR_W'(set_b) * ADDR_W'(WPS)) : '0;
    assign base_c = cmd.c_ok ? ADDR_W'(ADDR_W'(set_c) * ADDR_W'(WPS)) : '0;

endmodule

[rtl/bts_queue.sv]
// Small first-in first-out queue of classified words.
module bts_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid,
    output logic             full
);

    localparam int DEPTH = bts_pkg::QUEUE_DEPTH;
    localparam int PW    = bts_pkg::QPTR_W;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    wp_next;
    logic [PW-1:0]    rp_reg;
    logic [PW-1:0]    rp_next;
    logic [PW:0]      cnt_reg;
    logic [PW:0]      cnt_next;

    assign valid = (cnt_reg != '0);
    assign full  = (cnt_reg == (PW + 1)'(DEPTH));
    assign dout  = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

endmodule

[rtl/bts_back.sv]
// Back end: owns the set store and runs one operation at a time, issuing
// one step per cycle and handling the read data of a step in the cycle after.
module bts_back #(
    parameter int WORD_WIDTH    = 32,
    parameter int WORDS_PER_SET = 8,
    parameter int STORE_DEPTH   = 512
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    output logic                                   q_pop,
    input  bts_pkg::cmd_t                          cmd,
    input  logic [$clog2(STORE_DEPTH)-1:0]         base_a,
    input  logic [$clog2(STORE_DEPTH)-1:0]         base_b,
    input  logic [$clog2(STORE_DEPTH)-1:0]         base_c,
    input  logic [((WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1)-1:0] widx,
    input  logic [$clog2(WORD_WIDTH)-1:0]          bitpos,
    output logic                                   clearing,
    output logic                                   done,
    output logic                                   flag,
    output logic [bts_pkg::COUNT_W-1:0]            count
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int WIDX_W = (WORDS_PER_SET > 1) ? $clog2(WORDS_PER_SET) : 1;
    localparam int BIT_W  = $clog2(WORD_WIDTH);
    localparam int STP_W  = $clog2(2 * WORDS_PER_SET + 1);
    localparam int ACC_W  = $clog2(WORDS_PER_SET * WORD_WIDTH + 1);
    localparam int CW     = bts_pkg::COUNT_W;

    localparam logic [1:0] S_CLR   = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]            st_reg;
    logic [1:0]            st_next;
    logic [ADDR_W-1:0]     clr_reg;
    logic [ADDR_W-1:0]     clr_next;
    logic [STP_W-1:0]      stp_reg;
    logic [STP_W-1:0]      stp_next;
    logic                  pv_reg;
    logic                  pv_next;
    logic                  done_reg;
    logic                  done_next;

    bts_pkg::cmd_t         cmd_reg;
    logic [ADDR_W-1:0]     ba_reg;
    logic [ADDR_W-1:0]     bb_reg;
    logic [ADDR_W-1:0]     bc_reg;
    logic [WIDX_W-1:0]     widx_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [WIDX_W-1:0]     pw_reg;
    logic                  pph_reg;
    logic                  flg_reg;
    logic                  flg_next;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic [WORD_WIDTH-1:0] ab_reg;
    logic [WORD_WIDTH-1:0] ab_next;
    logic                  flag_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic [WORD_WIDTH-1:0] store_mem [STORE_DEPTH];
    logic [WORD_WIDTH-1:0] rd0_reg;
    logic [WORD_WIDTH-1:0] rd1_reg;

    logic [STP_W-1:0]      nstp;
    logic [WIDX_W-1:0]     step_w;
    logic                  step_ph;
    logic [ADDR_W-1:0]     addr0;
    logic [ADDR_W-1:0]     addr1;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [WORD_WIDTH-1:0] wdata;

    logic [WORD_WIDTH-1:0] wa;
    logic [WORD_WIDTH-1:0] wb;
    logic [WORD_WIDTH-1:0] wc;
    logic [WORD_WIDTH-1:0] bm;
    logic                  hit;
    logic                  pwe;
    logic [WORD_WIDTH-1:0] pwdata;
    logic [ADDR_W-1:0]     paddr;
    logic                  sat;

    assign clearing = (st_reg == S_CLR);
    assign q_pop    = (st_reg == S_IDLE) && q_valid;
    assign done     = done_reg;
    assign flag     = flag_reg;
    assign count    = count_reg;

    // Step plan: whole-set operations take one step per word, the disjoint
    // test two (first and second set, then the third), the rest one step.
    always_comb
    begin
        case (cmd_reg.op)
            bts_pkg::OP_CLEAR,
            bts_pkg::OP_MERGE,
            bts_pkg::OP_COUNT:
            begin
                nstp    = STP_W'(WORDS_PER_SET);
                step_w  = WIDX_W'(stp_reg);
                step_ph = 1'b0;
            end
            bts_pkg::OP_DISJ:
            begin
                nstp    = STP_W'(2 * WORDS_PER_SET);
                step_w  = WIDX_W'(stp_reg >> 1);
                step_ph = stp_reg[0];
            end
            default:
            begin
                nstp    = STP_W'(1);
                step_w  = widx_reg;
                step_ph = 1'b0;
            end
        endcase
    end

    assign addr0 = (step_ph ? bc_reg : ba_reg) + ADDR_W'(step_w);
    assign addr1 = bb_reg + ADDR_W'(step_w);
    assign paddr = ba_reg + ADDR_W'(pw_reg);

    // Handling of the read data of the previous step.
    always_comb
    begin
        wa       = cmd_reg.a_ok ? rd0_reg : '0;
        wb       = cmd_reg.b_ok ? rd1_reg : '0;
        wc       = cmd_reg.c_ok ? rd0_reg : '0;
        bm       = WORD_WIDTH'(1) << bit_reg;
        hit      = |(wa & bm);
        flg_next = flg_reg;
        acc_next = acc_reg;
        ab_next  = ab_reg;
        pwe      = 1'b0;
        pwdata   = wa;
        if (pv_reg)
        begin
            case (cmd_reg.op)
                bts_pkg::OP_ADD:
                begin
                    pwdata = wa | bm;
                    if (cmd_reg.a_ok && cmd_reg.tok_ok && !hit)
                    begin
                        pwe      = 1'b1;
                        flg_next = 1'b1;
                    end
                end
                bts_pkg::OP_REMOVE:
                begin
                    pwdata = wa & ~bm;
                    if (cmd_reg.a_ok && cmd_reg.tok_ok && hit)
                    begin
                        pwe      = 1'b1;
                        flg_next = 1'b1;
                    end
                end
                bts_pkg::OP_TEST:
                begin
                    if (cmd_reg.tok_ok && hit)
                    begin
                        flg_next = 1'b1;
                    end
                end
                bts_pkg::OP_MERGE:
                begin
                    pwdata = wa | wb;
                    if (cmd_reg.a_ok)
                    begin
                        pwe = 1'b1;
                        if ((wa | wb) != wa)
                        begin
                            flg_next = 1'b1;
                        end
                    end
                end
                bts_pkg::OP_COUNT:
                begin
                    acc_next = acc_reg + ACC_W'($countones(wa));
                end
                bts_pkg::OP_DISJ:
                begin
                    if (!pph_reg)
                    begin
                        ab_next = wa & wb;
                    end
                    else if (|(ab_reg & wc))
                    begin
                        flg_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Single write port: reset sweep, clear operation, or read-modify-write.
    always_comb
    begin
        if (st_reg == S_CLR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if ((st_reg == S_RUN) && (cmd_reg.op == bts_pkg::OP_CLEAR))
        begin
            we    = cmd_reg.a_ok;
            waddr = addr0;
            wdata = '0;
        end
        else
        begin
            we    = pwe;
            waddr = paddr;
            wdata = pwdata;
        end
    end

    assign sat = ({{(32 - ACC_W){1'b0}}, acc_next} > 32'(bts_pkg::COUNT_MAX));

    always_comb
    begin
        st_next    = st_reg;
        clr_next   = clr_reg;
        stp_next   = stp_reg;
        pv_next    = 1'b0;
        done_next  = 1'b0;
        count_next = '0;
        case (st_reg)
            S_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                stp_next = '0;
                if (q_valid)
                begin
                    st_next = S_RUN;
                end
            end
            S_RUN:
            begin
                pv_next  = 1'b1;
                stp_next = stp_reg + 1'b1;
                if (stp_reg == nstp - 1'b1)
                begin
                    st_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                done_next = 1'b1;
                if (cmd_reg.op == bts_pkg::OP_COUNT)
                begin
                    count_next = sat ? bts_pkg::COUNT_MAX : CW'(acc_next);
                end
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLR;
            clr_reg  <= '0;
            stp_reg  <= '0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            stp_reg  <= stp_next;
            pv_reg   <= pv_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg  <= cmd;
            ba_reg   <= base_a;
            bb_reg   <= base_b;
            bc_reg   <= base_c;
            widx_reg <= widx;
            bit_reg  <= bitpos;
            flg_reg  <= (cmd.op == bts_pkg::OP_DISJ);
            acc_reg  <= '0;
        end
        else
        begin
            flg_reg  <= flg_next;
            acc_reg  <= acc_next;
        end
        ab_reg    <= ab_next;
        pw_reg    <= step_w;
        pph_reg   <= step_ph;
        flag_reg  <= flg_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rd0_reg <= store_mem[addr0];
        rd1_reg <= store_mem[addr1];
    end

`ifndef SYNTH
    // A result appears only in the cycle after the last step was handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(st_reg == S_DRAIN))
        else $error("result strobe without a finished operation");

    // Only the count operation reports a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (count_reg != '0)) |-> $past(cmd_reg.op == bts_pkg::OP_COUNT))
        else $error("nonzero count from an operation other than count");

    // The step counter never runs past the plan of the current operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RUN) |-> (stp_reg < nstp))
        else $error("step counter beyond the operation's step count");

    // Read data is handled only for a step issued in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> $past(st_reg == S_RUN))
        else $error("read data handled without an issued step");

    // Nothing leaves the queue while the store is being swept after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("word taken from the queue during the reset sweep");
`endif

endmodule

[rtl/bitset_token_set_engine.sv]
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+-------------------------------
// command   | operation, set_a, set_b, set_c, token         | taken when start & !busy
// result    | flag, count                                   | done high for one cycle
//
// One result word follows every command word, in order.
// Single-token operations (add, remove, member test) touch a single store word in the back
// end; clear, merge and count walk every word of a set, and the disjoint test walks
// the words of the first and second set and then those of the third.
// The step sequencer moves one store word per cycle through the two read ports and
// the one write port of the set store.
// After reset, busy stays high while the store is swept to zero.
// busy also rises while the two-word command queue is full; the result side
// has no stall, so done simply pulses when an operation finishes.
module bitset_token_set_engine #(
    parameter int NUM_SETS    = 64,
    parameter int TOKEN_LIMIT = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bts_pkg::OP_W-1:0]      operation,
    input  logic [bts_pkg::SET_W-1:0]     set_a,
    input  logic [bts_pkg::SET_W-1:0]     set_b,
    input  logic [bts_pkg::SET_W-1:0]     set_c,
    input  logic [bts_pkg::TOKEN_W-1:0]   token,
    output logic                          done,
    output logic                          flag,
    output logic [bts_pkg::COUNT_W-1:0]   count
);

    // Each set is a bit vector of TOKEN_LIMIT bits kept in WPS store words;
    // token t of set s is bit (t mod WORD_WIDTH) of word s * WPS + t / WORD_WIDTH.
    localparam int WPS     = (TOKEN_LIMIT + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int DEPTH   = NUM_SETS * WPS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIDX_W  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int BIT_W   = $clog2(WORD_WIDTH);
    localparam int CMD_W   = $bits(bts_pkg::cmd_t);
    localparam int ENTRY_W = CMD_W + 3 * ADDR_W + WIDX_W + BIT_W;

    bts_pkg::cmd_t      f_cmd;
    logic [ADDR_W-1:0]  f_base_a;
    logic [ADDR_W-1:0]  f_base_b;
    logic [ADDR_W-1:0]  f_base_c;
    logic [WIDX_W-1:0]  f_widx;
    logic [BIT_W-1:0]   f_bitpos;

    bts_pkg::cmd_t      q_cmd;
    logic [ADDR_W-1:0]  q_base_a;
    logic [ADDR_W-1:0]  q_base_b;
    logic [ADDR_W-1:0]  q_base_c;
    logic [WIDX_W-1:0]  q_widx;
    logic [BIT_W-1:0]   q_bitpos;

    logic [ENTRY_W-1:0] q_din;
    logic [ENTRY_W-1:0] q_dout;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic               q_full;
    logic               clearing;

    // The command is taken whenever the queue has room and the reset sweep is
    // over; busy never looks at start.
    assign busy   = clearing | q_full;
    assign q_push = start & ~busy;

    // The front end classifies the command word in the cycle it arrives:
    // range checks, word index and bit position, and set base addresses.
    bts_front #(
        .NUM_SETS    (NUM_SETS),
        .TOKEN_LIMIT (TOKEN_LIMIT),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_front (
        .operation (operation),
        .set_a     (set_a),
        .set_b     (set_b),
        .set_c     (set_c),
        .token     (token),
        .cmd       (f_cmd),
        .base_a    (f_base_a),
        .base_b    (f_base_b),
        .base_c    (f_base_c),
        .widx      (f_widx),
        .bitpos    (f_bitpos)
    );

    assign q_din = {f_cmd, f_base_a, f_base_b, f_base_c, f_widx, f_bitpos};

    // The queue lets new commands arrive while the back end is still walking
    // the words of a long operation.
    bts_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .valid (q_valid),
        .full  (q_full)
    );

    assign {q_cmd, q_base_a, q_base_b, q_base_c, q_widx, q_bitpos} = q_dout;

    // The back end holds the set store and produces the result words.
    bts_back #(
        .WORD_WIDTH    (WORD_WIDTH),
        .WORDS_PER_SET (WPS),
        .STORE_DEPTH   (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .cmd      (q_cmd),
        .base_a   (q_base_a),
        .base_b   (q_base_b),
        .base_c   (q_base_c),
        .widx     (q_widx),
        .bitpos   (q_bitpos),
        .clearing (clearing),
        .done     (done),
        .flag     (flag),
        .count    (count)
    );

endmodule
